[hw/rtl/atl_pkg.sv]
`default_nettype none

package atl_pkg;

  localparam int VAL_W       = 63;
  localparam int KIND_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    K_NEWLINE = 4'd0,
    K_COMMA   = 4'd1,
    K_COLON   = 4'd2,
    K_LPAREN  = 4'd3,
    K_RPAREN  = 4'd4,
    K_PLUS    = 4'd5,
    K_MINUS   = 4'd6,
    K_IMM     = 4'd7,
    K_REG     = 4'd8,
    K_IDENT   = 4'd9,
    K_END     = 4'd10
  } tok_kind_t;

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] value;
  } acc_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // value * base + digit, saturating at the largest signed 64-bit value
  function automatic acc_res_t atl_accum(logic [VAL_W-1:0] acc, logic [3:0] digit,
                                         logic hex);
    logic [VAL_W+4:0] prod;
    logic [VAL_W+4:0] sum;
    acc_res_t         res;
    prod = hex ? {1'b0, acc, 4'b0000}
               : ({2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0});
    sum  = prod + {{(VAL_W+1){1'b0}}, digit};
    res.sat   = |sum[VAL_W+4:VAL_W];
    res.value = res.sat ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/assembler_token_lexer_unit.sv]
`default_nettype none

// channel  dir  tdata (low bit up)                               tuser       tlast
// s_*      in   ch[7:0]                                          req_type    -
// m_*      out  token_value[62:0], token_line, text_start,       token_kind  last_result
//               text_length (POS_WIDTH each), value_overflow,
//               zero fill to whole bytes
//
// one source word a cycle while the token queue has room; a word that both closes an
// open token and makes a second token holds s_tready low until the second token is
// written, as the token queue takes one word a cycle
// a token passes through the token queue and then the output register before it reaches m_*
// the front keeps taking words while m_* stalls until the four-word queue fills
// synchronous reset returns scan state, offset and line to start; no clearing pass

module assembler_token_lexer_unit import atl_pkg::*; #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [7:0]                                  s_tdata,   // ch
  input  logic [0:0]                                  s_tuser,   // req_type
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [((VAL_W+3*POS_WIDTH+1+7)/8)*8-1:0]    m_tdata,   // see table above
  output logic [KIND_W-1:0]                           m_tuser,   // token_kind
  output logic                                        m_tlast
);

  localparam int TOK_W  = VAL_W + 3 * POS_WIDTH + KIND_W + 2;
  localparam int DATA_W = ((VAL_W + 3 * POS_WIDTH + 1 + 7) / 8) * 8;

  q_stat_t          q_stat;
  logic             wr_en;
  logic [TOK_W-1:0] wr_data;
  logic             rd_en;
  logic [TOK_W-1:0] rd_data;

  atl_front #(
    .POS_WIDTH (POS_WIDTH),
    .TOK_W     (TOK_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  atl_fifo #(
    .TOK_W (TOK_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .stat    (q_stat)
  );

  atl_back #(
    .POS_WIDTH (POS_WIDTH),
    .TOK_W     (TOK_W),
    .DATA_W    (DATA_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[hw/rtl/atl_fifo.sv]
`default_nettype none

module atl_fifo import atl_pkg::*; #(
  parameter int TOK_W = 141
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [TOK_W-1:0] wr_data,
  input  logic             rd_en,
  output logic [TOK_W-1:0] rd_data,
  output q_stat_t          stat
);

  logic [TOK_W-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign push       = wr_en & ~stat.full;
  assign pop        = rd_en & ~stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10: count <= count + QCNT_W'(1);
        2'b01: count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/atl_front.sv]
`default_nettype none

module atl_front import atl_pkg::*; #(
  parameter int POS_WIDTH = 24,
  parameter int TOK_W     = VAL_W + 3 * POS_WIDTH + KIND_W + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic [0:0]       s_tuser,
  input  q_stat_t          q_stat,
  output logic             wr_en,
  output logic [TOK_W-1:0] wr_data
);

  localparam logic [POS_WIDTH-1:0] POS_ZERO = '0;
  localparam logic [POS_WIDTH-1:0] POS_ONE  = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_MAX  = '1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_XU     = 8'h58;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_SLASH   = 8'b0000_0100,
    M_XPEND   = 8'b0000_1000,
    M_DEC     = 8'b0001_0000,
    M_HEX     = 8'b0010_0000,
    M_REG     = 8'b0100_0000,
    M_IDENT   = 8'b1000_0000
  } mode_t;

  function automatic logic [POS_WIDTH-1:0] sat_inc(logic [POS_WIDTH-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  mode_t                mode, mode_next;
  logic [VAL_W-1:0]     accum, accum_next;
  logic                 acc_ovf, acc_ovf_next;
  logic                 dec_stop, dec_stop_next;
  logic [POS_WIDTH-1:0] start_off, start_off_next;
  logic [POS_WIDTH-1:0] start_line, start_line_next;
  logic [POS_WIDTH-1:0] text_count, text_count_next;
  logic [POS_WIDTH-1:0] src_off, src_off_next;
  logic [POS_WIDTH-1:0] src_line, src_line_next;
  logic                 pend_v;
  logic [TOK_W-1:0]     pend_tok;

  logic       accept;
  logic [7:0] c;
  logic       is_end;
  logic       is_dig, is_alpha, is_hexl, is_istart, is_icont;
  logic [3:0] hex_digit;
  acc_res_t   acc10, acc16;

  logic       f_tok_v, f_nl, f_begin;
  tok_kind_t  f_kind;
  mode_t      f_mode;

  logic             flush_ok;
  logic             a_v, b_v, do_fresh;
  tok_kind_t        a_kind, b_kind;
  logic [VAL_W-1:0] a_val;
  logic             a_ovf;
  logic [TOK_W-1:0] tok_a, tok_b;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = ~pend_v & ~q_stat.full;
  assign c        = s_tdata;
  assign is_end   = s_tuser[0];

  assign is_dig    = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha  = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  assign is_hexl   = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  assign is_istart = is_alpha || (c == CH_USCORE) || (c == CH_DOT);
  assign is_icont  = is_istart || is_dig;
  assign hex_digit = is_dig ? c[3:0] : (c[3:0] + 4'd9);

  assign acc10 = atl_accum(accum, c[3:0], 1'b0);
  assign acc16 = atl_accum(accum, hex_digit, 1'b1);

  // what a byte does when it starts afresh
  always_comb begin
    f_tok_v = 1'b0;
    f_nl    = 1'b0;
    f_begin = 1'b0;
    f_kind  = K_NEWLINE;
    f_mode  = M_IDLE;
    unique case (c)
      CH_SPACE, CH_TAB, CH_CR: begin
      end
      CH_HASH:  f_mode = M_COMMENT;
      CH_SLASH: f_mode = M_SLASH;
      CH_LF: begin
        f_tok_v = 1'b1;
        f_nl    = 1'b1;
      end
      CH_COMMA: begin
        f_tok_v = 1'b1;
        f_kind  = K_COMMA;
      end
      CH_COLON: begin
        f_tok_v = 1'b1;
        f_kind  = K_COLON;
      end
      CH_LPAR: begin
        f_tok_v = 1'b1;
        f_kind  = K_LPAREN;
      end
      CH_RPAR: begin
        f_tok_v = 1'b1;
        f_kind  = K_RPAREN;
      end
      CH_PLUS: begin
        f_tok_v = 1'b1;
        f_kind  = K_PLUS;
      end
      CH_MINUS: begin
        f_tok_v = 1'b1;
        f_kind  = K_MINUS;
      end
      default: begin
        if (is_dig) begin
          f_mode  = M_DEC;
          f_begin = 1'b1;
        end else if (c == CH_X) begin
          f_mode  = M_XPEND;
          f_begin = 1'b1;
        end else if (is_istart) begin
          f_mode  = M_IDENT;
          f_begin = 1'b1;
        end
      end
    endcase
  end

  // open token as it would be closed now
  always_comb begin
    flush_ok = 1'b1;
    a_kind   = K_IDENT;
    a_val    = '0;
    a_ovf    = 1'b0;
    unique case (mode)
      M_DEC, M_HEX: begin
        a_kind = K_IMM;
        a_val  = accum;
        a_ovf  = acc_ovf;
      end
      M_REG: begin
        a_kind = K_REG;
        a_val  = accum;
        a_ovf  = acc_ovf;
      end
      M_IDENT, M_XPEND: begin
      end
      default: flush_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_next       = mode;
    accum_next      = accum;
    acc_ovf_next    = acc_ovf;
    dec_stop_next   = dec_stop;
    start_off_next  = start_off;
    start_line_next = start_line;
    text_count_next = text_count;
    src_off_next    = src_off;
    src_line_next   = src_line;
    a_v             = 1'b0;
    do_fresh        = 1'b0;
    if (is_end) begin
      a_v             = flush_ok;
      mode_next       = M_IDLE;
      accum_next      = '0;
      acc_ovf_next    = 1'b0;
      dec_stop_next   = 1'b0;
      start_off_next  = '0;
      start_line_next = POS_ONE;
      text_count_next = '0;
      src_off_next    = '0;
      src_line_next   = POS_ONE;
    end else begin
      src_off_next = sat_inc(src_off);
      unique case (mode)
        M_XPEND: begin
          if (is_dig) begin
            mode_next       = M_REG;
            accum_next      = {{(VAL_W-4){1'b0}}, c[3:0]};
            text_count_next = sat_inc(text_count);
          end else if (is_icont) begin
            mode_next       = M_IDENT;
            text_count_next = sat_inc(text_count);
          end else begin
            a_v      = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) begin
            do_fresh = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            do_fresh = 1'b1;
          end
        end
        M_DEC: begin
          if ((text_count == POS_ONE) && (accum == '0) && ((c == CH_X) || (c == CH_XU))) begin
            mode_next       = M_HEX;
            text_count_next = sat_inc(text_count);
          end else if (is_dig || is_hexl) begin
            if (!is_dig) begin
              dec_stop_next = 1'b1;
            end else if (!dec_stop) begin
              accum_next   = acc10.value;
              acc_ovf_next = acc_ovf | acc10.sat;
            end
            text_count_next = sat_inc(text_count);
          end else begin
            a_v      = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_HEX: begin
          if (is_dig || is_hexl) begin
            accum_next      = acc16.value;
            acc_ovf_next    = acc_ovf | acc16.sat;
            text_count_next = sat_inc(text_count);
          end else begin
            a_v      = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_REG: begin
          if (is_dig) begin
            accum_next      = acc10.value;
            acc_ovf_next    = acc_ovf | acc10.sat;
            text_count_next = sat_inc(text_count);
          end else begin
            a_v      = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_icont) begin
            text_count_next = sat_inc(text_count);
          end else begin
            a_v      = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase
      if (do_fresh) begin
        mode_next = f_mode;
        if (f_nl) begin
          src_line_next = sat_inc(src_line);
        end
        if (f_begin) begin
          accum_next      = is_dig ? {{(VAL_W-4){1'b0}}, c[3:0]} : '0;
          acc_ovf_next    = 1'b0;
          dec_stop_next   = 1'b0;
          start_off_next  = src_off;
          start_line_next = src_line;
          text_count_next = POS_ONE;
        end
      end
    end
  end

  assign b_v    = is_end | (do_fresh & f_tok_v);
  assign b_kind = is_end ? K_END : f_kind;

  // word layout: last, kind, overflow, length, start, line, value
  assign tok_a = {~b_v, a_kind, a_ovf, text_count, start_off, start_line, a_val};
  assign tok_b = {1'b1, b_kind, 1'b0, (is_end ? POS_ZERO : POS_ONE), src_off, src_line,
                  {VAL_W{1'b0}}};

  always_comb begin
    if (pend_v) begin
      wr_en   = ~q_stat.full;
      wr_data = pend_tok;
    end else begin
      wr_en   = accept & (a_v | b_v);
      wr_data = a_v ? tok_a : tok_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      accum      <= '0;
      acc_ovf    <= 1'b0;
      dec_stop   <= 1'b0;
      start_off  <= '0;
      start_line <= POS_ONE;
      text_count <= '0;
      src_off    <= '0;
      src_line   <= POS_ONE;
      pend_v     <= 1'b0;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        accum      <= accum_next;
        acc_ovf    <= acc_ovf_next;
        dec_stop   <= dec_stop_next;
        start_off  <= start_off_next;
        start_line <= start_line_next;
        text_count <= text_count_next;
        src_off    <= src_off_next;
        src_line   <= src_line_next;
      end
      if (accept && a_v && b_v) begin
        pend_v <= 1'b1;
      end else if (pend_v && !q_stat.full) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_tok <= tok_b;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/atl_back.sv]
`default_nettype none

module atl_back import atl_pkg::*; #(
  parameter int POS_WIDTH = 24,
  parameter int TOK_W     = VAL_W + 3 * POS_WIDTH + KIND_W + 2,
  parameter int DATA_W    = ((VAL_W + 3 * POS_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  q_stat_t           q_stat,
  input  logic [TOK_W-1:0]  rd_data,
  output logic              rd_en,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0] m_tuser,
  output logic              m_tlast
);

  localparam int DATA_BITS = VAL_W + 3 * POS_WIDTH + 1;

  logic [TOK_W-1:0] tok_q;

  assign rd_en    = ~q_stat.empty & (~m_tvalid | m_tready);
  assign m_tdata  = DATA_W'(tok_q[DATA_BITS-1:0]);
  assign m_tuser  = tok_q[DATA_BITS +: KIND_W];
  assign m_tlast  = tok_q[TOK_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tok_q <= rd_data;
    end
  end

endmodule

`default_nettype wire

[test/tb_assembler_token_lexer_unit.sv]
`default_nettype none

module tb_assembler_token_lexer_unit;
  import atl_pkg::*;

  localparam int POS_W     = 24;
  localparam int TDATA_W   = ((VAL_W + 3*POS_W + 1 + 7)/8)*8;
  localparam int LINE_LSB  = VAL_W;
  localparam int START_LSB = VAL_W + POS_W;
  localparam int LEN_LSB   = VAL_W + 2*POS_W;
  localparam int OVF_BIT   = VAL_W + 3*POS_W;
  localparam int LIMIT     = 200000;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  typedef enum logic [2:0] {
    SM_IDLE, SM_COMMENT, SM_SLASH, SM_XPEND, SM_DEC, SM_HEX, SM_REG, SM_IDENT
  } scan_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] line_no;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
    logic             ovf;
    logic             last;
  } token_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;
  logic [0:0]         s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]  m_tuser;
  logic               m_tlast;

  assembler_token_lexer_unit #(.POS_WIDTH(POS_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // lexer state as predicted
  scan_t            scan;
  logic [63:0]      acc;
  logic             acc_sat;
  logic             dec_stop;
  logic [POS_W-1:0] tok_off;
  logic [POS_W-1:0] tok_line;
  logic [POS_W-1:0] tok_len;
  logic [POS_W-1:0] src_off;
  logic [POS_W-1:0] src_line;

  token_t       word_tokens[$];
  token_t       expected_tokens[$];
  byte unsigned src_text[$];

  int  errors = 0;
  int  words_sent = 0;
  int  ends_sent = 0;
  int  tokens_seen = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b0;
  bit  stall_on = 1'b0;
  logic [31:0] stall_pattern = 32'hFFFF_FFFF;
  logic [4:0]  stall_idx = 5'd0;
  token_t got_tok;
  token_t want_tok;

  string dec_s   = "0123456789";
  string hex_s   = "0123456789abcdefABCDEF";
  string hexl_s  = "abcdefABCDEF";
  string first_s = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.";
  string cont_s  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.0123456789";

  function automatic logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic bit is_digit(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex_letter(byte unsigned c);
    return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_ident_start(byte unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ".";
  endfunction

  function automatic logic [63:0] digit_val(byte unsigned c);
    return 64'(c) - 64'h30;
  endfunction

  function automatic logic [63:0] hex_digit(byte unsigned c);
    if (is_digit(c)) return digit_val(c);
    if (c >= "a" && c <= "f") return 64'(c) - 64'h61 + 64'd10;
    return 64'(c) - 64'h41 + 64'd10;
  endfunction

  function automatic string token_text(token_t t);
    return $sformatf("kind %0d value %0d line %0d start %0d len %0d ovf %0b last %0b",
                     t.kind, t.value, t.line_no, t.start, t.len, t.ovf, t.last);
  endfunction

  task automatic clear_scan();
    scan     = SM_IDLE;
    acc      = '0;
    acc_sat  = 1'b0;
    dec_stop = 1'b0;
    tok_off  = '0;
    tok_line = POS_ONE;
    tok_len  = '0;
    src_off  = '0;
    src_line = POS_ONE;
  endtask

  task automatic add_token(input tok_kind_t kind, input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] line_no, input logic [POS_W-1:0] start,
                           input logic [POS_W-1:0] len, input logic ovf);
    token_t t;
    t.kind    = kind;
    t.value   = value;
    t.line_no = line_no;
    t.start   = start;
    t.len     = len;
    t.ovf     = ovf;
    t.last    = 1'b0;
    word_tokens.insert(word_tokens.size(), t);
  endtask

  task automatic accumulate(input logic [63:0] digit, input logic [63:0] base);
    if (acc > (VAL_MAX - digit) / base) begin
      acc     = VAL_MAX;
      acc_sat = 1'b1;
    end else begin
      acc = acc * base + digit;
    end
  endtask

  task automatic open_token(input scan_t mode, input logic [POS_W-1:0] off);
    scan     = mode;
    acc      = '0;
    acc_sat  = 1'b0;
    dec_stop = 1'b0;
    tok_off  = off;
    tok_line = src_line;
    tok_len  = POS_ONE;
  endtask

  task automatic close_token();
    case (scan)
      SM_DEC, SM_HEX: add_token(K_IMM, acc[VAL_W-1:0], tok_line, tok_off, tok_len, acc_sat);
      SM_REG:         add_token(K_REG, acc[VAL_W-1:0], tok_line, tok_off, tok_len, acc_sat);
      SM_IDENT, SM_XPEND: add_token(K_IDENT, '0, tok_line, tok_off, tok_len, 1'b0);
      default: ;
    endcase
    scan = SM_IDLE;
  endtask

  task automatic lex_fresh(input byte unsigned c, input logic [POS_W-1:0] off);
    scan = SM_IDLE;
    case (c)
      " ", 8'h09, 8'h0D: ;
      "#": scan = SM_COMMENT;
      "/": scan = SM_SLASH;
      8'h0A: begin
        add_token(K_NEWLINE, '0, src_line, off, POS_ONE, 1'b0);
        src_line = sat_inc(src_line);
      end
      ",": add_token(K_COMMA, '0, src_line, off, POS_ONE, 1'b0);
      ":": add_token(K_COLON, '0, src_line, off, POS_ONE, 1'b0);
      "(": add_token(K_LPAREN, '0, src_line, off, POS_ONE, 1'b0);
      ")": add_token(K_RPAREN, '0, src_line, off, POS_ONE, 1'b0);
      "+": add_token(K_PLUS, '0, src_line, off, POS_ONE, 1'b0);
      "-": add_token(K_MINUS, '0, src_line, off, POS_ONE, 1'b0);
      default: begin
        if (is_digit(c)) begin
          open_token(SM_DEC, off);
          acc = digit_val(c);
        end else if (c == "x") begin
          open_token(SM_XPEND, off);
        end else if (is_ident_start(c)) begin
          open_token(SM_IDENT, off);
        end
      end
    endcase
  endtask

  // works out the tokens that one accepted word causes
  task automatic lex_word(input bit is_end, input byte unsigned c);
    logic [POS_W-1:0] off;
    bit               taken;
    off = src_off;
    taken = 1'b0;
    word_tokens.delete();
    if (is_end) begin
      close_token();
      add_token(K_END, '0, src_line, src_off, '0, 1'b0);
      clear_scan();
    end else begin
      src_off = sat_inc(src_off);
      if (scan == SM_XPEND) begin
        if (is_digit(c)) begin
          scan    = SM_REG;
          acc     = digit_val(c);
          tok_len = sat_inc(tok_len);
          taken   = 1'b1;
        end else begin
          scan = SM_IDENT;
        end
      end
      if (!taken) begin
        case (scan)
          SM_COMMENT: if (c == 8'h0A) lex_fresh(c, off);
          SM_SLASH: begin
            if (c == "/") scan = SM_COMMENT;
            else lex_fresh(c, off);
          end
          SM_DEC: begin
            if (tok_len == POS_ONE && acc == 64'd0 && (c == "x" || c == "X")) begin
              scan    = SM_HEX;
              tok_len = sat_inc(tok_len);
            end else if (is_digit(c) || is_hex_letter(c)) begin
              if (!is_digit(c)) dec_stop = 1'b1;
              else if (!dec_stop) accumulate(digit_val(c), 64'd10);
              tok_len = sat_inc(tok_len);
            end else begin
              close_token();
              lex_fresh(c, off);
            end
          end
          SM_HEX: begin
            if (is_digit(c) || is_hex_letter(c)) begin
              accumulate(hex_digit(c), 64'd16);
              tok_len = sat_inc(tok_len);
            end else begin
              close_token();
              lex_fresh(c, off);
            end
          end
          SM_REG: begin
            if (is_digit(c)) begin
              accumulate(digit_val(c), 64'd10);
              tok_len = sat_inc(tok_len);
            end else begin
              close_token();
              lex_fresh(c, off);
            end
          end
          SM_IDENT: begin
            if (is_ident_start(c) || is_digit(c)) begin
              tok_len = sat_inc(tok_len);
            end else begin
              close_token();
              lex_fresh(c, off);
            end
          end
          default: lex_fresh(c, off);
        endcase
      end
    end
    if (word_tokens.size() != 0) word_tokens[word_tokens.size()-1].last = 1'b1;
    foreach (word_tokens[i]) expected_tokens.insert(expected_tokens.size(), word_tokens[i]);
  endtask

  task automatic send_word(input bit is_end, input byte unsigned c);
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= is_end;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    lex_word(is_end, c);
    words_sent++;
    if (is_end) ends_sent++;
  endtask

  task automatic send_text();
    foreach (src_text[i]) send_word(1'b0, src_text[i]);
    src_text.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_byte(input byte unsigned b);
    src_text.insert(src_text.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_chars(input string set, input int n);
    repeat (n) put_byte(set[$urandom_range(0, set.len() - 1)]);
  endtask

  task automatic put_blanks(input int lo);
    repeat ($urandom_range(lo, 2)) begin
      case ($urandom_range(0, 5))
        0: put_byte(8'h09);
        1: put_byte(8'h0D);
        default: put_byte(" ");
      endcase
    end
  endtask

  task automatic put_ident();
    put_chars(first_s, 1);
    put_chars(cont_s, ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5));
  endtask

  task automatic put_reg();
    put_str("x");
    put_chars(dec_s, ($urandom_range(0, 9) == 0) ? $urandom_range(19, 22) : $urandom_range(1, 2));
  endtask

  task automatic put_imm();
    case ($urandom_range(0, 7))
      0, 1, 2: put_chars(dec_s, $urandom_range(1, 4));
      3: put_chars(dec_s, $urandom_range(18, 22));
      4: begin
        put_str($urandom_range(0, 1) ? "0x" : "0X");
        put_chars(hex_s, $urandom_range(1, 8));
      end
      5: begin
        put_str("0x");
        put_chars(hex_s, $urandom_range(15, 18));
      end
      6: put_str("0x");
      default: begin
        put_chars(dec_s, $urandom_range(1, 3));
        put_chars(hexl_s, $urandom_range(1, 2));
        put_chars(hex_s, $urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic put_operand();
    case ($urandom_range(0, 8))
      0, 1, 2, 3: put_reg();
      4, 5, 6: begin
        if ($urandom_range(0, 2) == 0) put_str($urandom_range(0, 1) ? "-" : "+");
        put_imm();
      end
      7: put_ident();
      default: begin
        put_imm();
        put_str("(");
        put_reg();
        put_str(")");
      end
    endcase
  endtask

  task automatic put_line();
    int n;
    n = $urandom_range(0, 5);
    if (n == 0 || n == 4) begin
      put_ident();
      put_str(":");
    end
    if (n >= 1 && n <= 4) begin
      put_blanks(0);
      put_ident();
      put_blanks(1);
      for (int k = 0; k < $urandom_range(1, 3); k++) begin
        if (k != 0) begin
          put_blanks(0);
          put_str(",");
          put_blanks(0);
        end
        put_operand();
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      put_blanks(0);
      put_str($urandom_range(0, 1) ? "#" : "//");
      repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(32, 126)));
    end
    put_byte(8'h0A);
  endtask

  task automatic test_single_char_tokens();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    put_str(",:()+-");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(" ");
    put_byte(8'h09);
    put_byte(8'h0D);
    put_byte(8'h0A);
    send_text();
    wait_drained();
  endtask

  task automatic test_numbers_registers();
    stall_on = 1'b1;
    put_str("0x 12ab3 x12 xq;");
    send_text();
    send_word(1'b1, 8'hFF);
    wait_drained();
  endtask

  task automatic test_comments();
    put_str("/a//c");
    put_byte(8'h0A);
    put_str("#z");
    send_text();
    send_word(1'b1, 8'h00);
    wait_drained();
  endtask

  task automatic test_end_of_source();
    gaps_on = 1'b1;
    send_word(1'b0, "7");
    send_word(1'b1, 8'h5A);
    send_word(1'b0, "x");
    send_word(1'b1, 8'hA5);
    send_word(1'b1, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_programs(input int n);
    int base;
    base = words_sent;
    while (words_sent - base < n) begin
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 6)) put_line();
      if ($urandom_range(0, 2) == 0) put_operand();
      send_text();
      send_word(1'b1, 8'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  task automatic test_random_noise(input int n);
    int base;
    base = words_sent;
    while (words_sent - base < n) begin
      if ($urandom_range(0, 15) == 0) begin
        gaps_on  = $urandom_range(0, 1);
        stall_on = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        4, 5, 6: put_operand();
        7: put_str($urandom_range(0, 1) ? "/" : "#");
        8: put_line();
        default: send_word(1'b1, 8'($urandom_range(0, 255)));
      endcase
      send_text();
    end
    send_word(1'b1, 8'h00);
    wait_drained();
  endtask

  // receiver stalls follow a rotating pattern, dense or sparse
  always @(negedge clk) begin
    if (stall_idx == 5'd0)
      stall_pattern = $urandom_range(0, 1) ? ($urandom | $urandom) : ($urandom & $urandom);
    stall_idx = stall_idx + 5'd1;
    m_tready <= !stall_on || stall_pattern[stall_idx];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_tok.kind    = tok_kind_t'(m_tuser);
      got_tok.value   = m_tdata[VAL_W-1:0];
      got_tok.line_no = m_tdata[LINE_LSB +: POS_W];
      got_tok.start   = m_tdata[START_LSB +: POS_W];
      got_tok.len     = m_tdata[LEN_LSB +: POS_W];
      got_tok.ovf     = m_tdata[OVF_BIT];
      got_tok.last    = m_tlast;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        $display("%0t unexpected token: expected none, actual %s", $time, token_text(got_tok));
        errors++;
      end else begin
        want_tok = expected_tokens.pop_front();
        if (got_tok !== want_tok) begin
          $display("%0t token mismatch: expected %s, actual %s", $time,
                   token_text(want_tok), token_text(got_tok));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
               expected_tokens.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clear_scan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_char_tokens();
    test_numbers_registers();
    test_comments();
    test_end_of_source();
    test_random_programs(1150);
    test_random_noise(250);
    if (expected_tokens.size() != 0) errors++;
    $display("sent %0d source words including %0d end-of-source words, checked %0d tokens",
             words_sent, ends_sent, tokens_seen);
    $display("random programs, noise and broken fragments under sender gaps and output stalls");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
